### sv/nfee_pkg.sv
// Shared types and constants for the nibble frame escape encoder.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nfee_pkg;

	// Symbol slots of one item, in emission order.
	localparam int unsigned NUM_SLOTS = 10;
	localparam int unsigned SLOT_W    = 4;

	localparam logic [SLOT_W-1:0] SLOT_START0 = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_START1 = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_START2 = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_HI     = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_ESC_HI = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_LO     = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_ESC_LO = 4'd6;
	localparam logic [SLOT_W-1:0] SLOT_END0   = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_END1   = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_END2   = 4'd9;

	// Tone codes.
	localparam logic [3:0] TONE_FLAG0  = 4'd0;
	localparam logic [3:0] TONE_FLAG1  = 4'd1;
	localparam logic [3:0] TONE_FLAG2  = 4'd2;
	localparam logic [3:0] TONE_ESCAPE = 4'd3;
	localparam logic [3:0] NIB_ZERO    = 4'd0;
	localparam logic [3:0] NIB_ONE     = 4'd1;

	// Queue between front and back.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;
	localparam int unsigned Q_CNT_W = 3;

	// One classified item: which slots it emits and its two nibbles.
	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic [3:0]           hi;
		logic [3:0]           lo;
	} desc_t;

	// Tone emitted by a given slot.
	function automatic logic [3:0] slot_symbol(input logic [SLOT_W-1:0] slot,
			input logic [3:0] hi, input logic [3:0] lo);
		logic [3:0] sym;
		begin
			unique case (slot)
				SLOT_START0, SLOT_END0: sym = TONE_FLAG0;
				SLOT_START1, SLOT_END1: sym = TONE_FLAG1;
				SLOT_START2, SLOT_END2: sym = TONE_FLAG2;
				SLOT_HI:                sym = hi;
				SLOT_LO:                sym = lo;
				SLOT_ESC_HI, SLOT_ESC_LO: sym = TONE_ESCAPE;
				default:                sym = TONE_ESCAPE;
			endcase
			return sym;
		end
	endfunction

endpackage

`default_nettype wire

### sv/nfee_front.sv
// Front end: accepts input items, tracks frame state and escape history,
// and turns each item into a slot descriptor. Depends on nfee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nfee_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    data_byte,
	input  wire logic          carries_byte,
	input  wire logic          last_of_frame,
	output nfee_pkg::desc_t    desc
);
	import nfee_pkg::*;

	logic       frame_open_q;
	logic       prev_zero_q;
	logic       closing;
	logic       prev_zero_eff;
	logic [3:0] hi;
	logic [3:0] lo;
	logic       esc_hi;
	logic       esc_lo;

	// Classify the item against the current frame state.
	always_comb begin
		hi            = data_byte[7:4];
		lo            = data_byte[3:0];
		closing       = !carries_byte || last_of_frame;
		prev_zero_eff = frame_open_q && prev_zero_q;
		esc_hi        = carries_byte && (hi == NIB_ONE) && prev_zero_eff;
		esc_lo        = carries_byte && (lo == NIB_ONE) && (hi == NIB_ZERO);
	end

	// Build the slot mask in emission order.
	always_comb begin
		desc.hi   = hi;
		desc.lo   = lo;
		desc.mask = '0;
		desc.mask[SLOT_START0] = !frame_open_q;
		desc.mask[SLOT_START1] = !frame_open_q;
		desc.mask[SLOT_START2] = !frame_open_q;
		desc.mask[SLOT_HI]     = carries_byte;
		desc.mask[SLOT_ESC_HI] = esc_hi;
		desc.mask[SLOT_LO]     = carries_byte;
		desc.mask[SLOT_ESC_LO] = esc_lo;
		desc.mask[SLOT_END0]   = closing;
		desc.mask[SLOT_END1]   = closing;
		desc.mask[SLOT_END2]   = closing;
	end

	// Frame state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			prev_zero_q  <= 1'b0;
		end else if (accept) begin
			if (closing) begin
				frame_open_q <= 1'b0;
				prev_zero_q  <= 1'b0;
			end else begin
				frame_open_q <= 1'b1;
				prev_zero_q  <= carries_byte ? (lo == NIB_ZERO) : prev_zero_eff;
			end
		end
	end

endmodule

`default_nettype wire

### sv/nfee_queue.sv
// Short descriptor queue between the front and the back end.
// Depends on nfee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nfee_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire nfee_pkg::desc_t  wr_desc,
	input  wire logic             pop,
	output nfee_pkg::desc_t       rd_desc,
	output logic                  full,
	output logic                  empty
);
	import nfee_pkg::*;

	desc_t                mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full    = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_desc = mem_q[rd_ptr_q];

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count exceeds depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
	a_desc_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (wr_desc.mask != '0))
		else $error("descriptor with no symbols queued");

endmodule

`default_nettype wire

### sv/nfee_back.sv
// Back end: walks each descriptor's slot mask and emits one tone symbol
// per cycle into the output register unless stalled. Depends on nfee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nfee_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire nfee_pkg::desc_t  rd_desc,
	input  wire logic             empty,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);
	import nfee_pkg::*;

	logic [NUM_SLOTS-1:0] mask_q;
	logic [3:0]           hi_q;
	logic [3:0]           lo_q;
	logic                 tvalid_q;
	logic [3:0]           sym_q;
	logic                 last_q;

	logic                 out_free;
	logic                 emit;
	logic [NUM_SLOTS-1:0] remain;
	logic [SLOT_W-1:0]    sel;

	// Lowest pending slot is the next symbol.
	always_comb begin
		sel = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = SLOT_W'(i);
			end
		end
	end

	// Emit when a slot is pending and the output register can take it;
	// fetch the next descriptor as the current one drains.
	always_comb begin
		out_free = !tvalid_q || m_tready;
		emit     = out_free && (mask_q != '0);
		remain   = mask_q & (mask_q - 1'b1);
		pop      = !empty && ((mask_q == '0) || (emit && (remain == '0)));
	end

	// Current descriptor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (pop) begin
			mask_q <= rd_desc.mask;
		end else if (emit) begin
			mask_q <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hi_q <= rd_desc.hi;
			lo_q <= rd_desc.lo;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (out_free) begin
			tvalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sym_q  <= slot_symbol(sel, hi_q, lo_q);
			last_q <= (remain == '0);
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = {4'b0000, sym_q};
	assign m_tlast  = last_q;

	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (mask_q != '0))
		else $error("loaded descriptor has no symbols");
	a_start_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q[SLOT_START0] == mask_q[SLOT_START1]) ||
		(mask_q[SLOT_START1] && mask_q[SLOT_START2]) ||
		(!mask_q[SLOT_START0] && !mask_q[SLOT_START1] && mask_q[SLOT_START2]) ||
		(!mask_q[SLOT_START0] && !mask_q[SLOT_START1]))
		else $error("start flag slots out of order");
	a_escapes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mask_q[SLOT_ESC_HI] && mask_q[SLOT_ESC_LO]))
		else $error("both escape slots pending in one item");
	a_escape_follows_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q[SLOT_ESC_HI] && !mask_q[SLOT_HI]) |-> !mask_q[SLOT_START0])
		else $error("escape pending before start flag done");

endmodule

`default_nettype wire

### sv/nibble_frame_escape_encoder.sv
// Top level of the nibble frame escape encoder.
// Depends on nfee_pkg, nfee_front, nfee_queue and nfee_back.
`timescale 1ns / 1ps
`default_nettype none

// Encodes frame bytes into 4-bit tone symbols: a start flag 0,1,2 opens a
// frame, each byte goes out high nibble first, an escape 3 follows a data
// 1 that directly follows a data 0, and an end flag 0,1,2 closes the frame
// after an item with tlast set or with tuser (carries byte) clear. An input
// item is taken whenever the four-entry descriptor queue has room; the
// output runs at one symbol per cycle, unless m_tready stalls it, through
// a single output register. An item makes 2 or 3 symbols for a byte
// inside a frame, up to 9 with both flags. The sustained rate is set by
// that one-symbol-per-cycle output stage.
module nibble_frame_escape_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tuser,   // [0] carries_byte
	input  wire logic       s_tlast,   // last_of_frame
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [3:0] tone_symbol, [7:4] zero
	output logic            m_tlast    // last_symbol
);
	import nfee_pkg::*;

	desc_t wr_desc;
	desc_t rd_desc;
	logic  accept;
	logic  full;
	logic  empty;
	logic  pop;

	assign s_tready = !full;
	assign accept   = s_tvalid && !full;

	nfee_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (s_tdata),
		.carries_byte  (s_tuser),
		.last_of_frame (s_tlast),
		.desc          (wr_desc)
	);

	nfee_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.wr_desc (wr_desc),
		.pop     (pop),
		.rd_desc (rd_desc),
		.full    (full),
		.empty   (empty)
	);

	nfee_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_desc  (rd_desc),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### bench/tb_nibble_frame_escape_encoder.sv
// Self-checking testbench for nibble_frame_escape_encoder: directed table, then random frames.
// Depends on nfee_pkg for the tone codes and on the nibble_frame_escape_encoder RTL.
`timescale 1ns / 1ps

module tb_nibble_frame_escape_encoder;
	import nfee_pkg::*;

	localparam int RANDOM_ITEMS = 300;
	localparam int CALM_ITEMS   = 40;
	localparam int SETTLE_CYCLES = 20;

	// One expected output symbol.
	typedef struct packed {
		logic [3:0] tone;
		logic       last;
	} tone_exp_t;

	// One directed row; typed rows carry their symbols left-aligned, first symbol on top.
	typedef struct packed {
		logic [7:0]  data;
		logic        carries;
		logic        closes;
		logic        typed;
		logic [3:0]  count;
		logic [35:0] syms;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] data_byte
	logic       s_tuser;   // [0] carries_byte
	logic       s_tlast;   // last_of_frame
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [3:0] tone_symbol, [7:4] zero
	logic       m_tlast;   // last_symbol

	// Encoder state as the predictor sees it.
	logic       frame_is_open;
	logic       last_data_zero;
	logic [3:0] item_syms [0:8];
	int         item_len;

	tone_exp_t  expected_tones [$];
	stim_row_t  directed_rows [$];

	int  errors = 0;
	int  items_sent = 0;
	int  symbols_seen = 0;
	int  escapes_made = 0;
	int  frames_closed = 0;
	bit  calm = 1'b0;
	int  gap_odds = 0;

	nibble_frame_escape_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Append one symbol to the current item's list.
	function automatic void emit_tone(input logic [3:0] tone);
		item_syms[item_len] = tone;
		item_len++;
	endfunction

	function automatic void emit_flag();
		emit_tone(TONE_FLAG0);
		emit_tone(TONE_FLAG1);
		emit_tone(TONE_FLAG2);
	endfunction

	// A data 1 right after a data 0 is followed by an escape.
	function automatic void emit_nibble(input logic [3:0] nib);
		emit_tone(nib);
		if (nib == NIB_ONE && last_data_zero) begin
			emit_tone(TONE_ESCAPE);
			escapes_made++;
		end
		last_data_zero = (nib == NIB_ZERO);
	endfunction

	// Predict the symbols of one accepted item and advance the frame state.
	function automatic void encode_frame_item(input logic [7:0] b, input logic has_byte,
			input logic closes);
		item_len = 0;
		if (!frame_is_open) begin
			emit_flag();
			frame_is_open  = 1'b1;
			last_data_zero = 1'b0;
		end
		if (has_byte) begin
			emit_nibble(b[7:4]);
			emit_nibble(b[3:0]);
		end
		if (!has_byte || closes) begin
			emit_flag();
			frame_is_open  = 1'b0;
			last_data_zero = 1'b0;
			frames_closed++;
		end
	endfunction

	function automatic stim_row_t row(input logic [7:0] data, input logic carries,
			input logic closes, input logic typed, input logic [3:0] count,
			input logic [35:0] syms);
		stim_row_t r;
		r.data    = data;
		r.carries = carries;
		r.closes  = closes;
		r.typed   = typed;
		r.count   = count;
		r.syms    = syms;
		return r;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(input stim_row_t r);
		directed_rows = {directed_rows, r};
	endfunction

	// Bytes rich in 0 and 1 nibbles so escapes come often.
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if ($urandom_range(0, 1) == 0)
			b[7:4] = 4'($urandom_range(0, 1));
		if ($urandom_range(0, 1) == 0)
			b[3:0] = 4'($urandom_range(0, 1));
		return b;
	endfunction

	// Offer one item, wait for it to be taken, then queue its symbols.
	task automatic send_item(input logic [7:0] b, input logic has_byte, input logic closes,
			input logic typed, input logic [3:0] typed_count, input logic [35:0] typed_syms);
		int k;
		tone_exp_t e;
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= has_byte;
		s_tlast  <= closes;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		encode_frame_item(b, has_byte, closes);
		if (typed) begin
			item_len = int'(typed_count);
			for (k = 0; k < item_len; k++)
				item_syms[k] = typed_syms[35 - 4 * k -: 4];
		end
		for (k = 0; k < item_len; k++) begin
			e.tone = item_syms[k];
			e.last = (k == item_len - 1);
			expected_tones = {expected_tones, e};
		end
		items_sent++;
	endtask

	// Hold the input side until every queued symbol has come out.
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_tones.size() != 0) @(posedge clk);
	endtask

	// Compare each accepted symbol with the oldest expectation.
	always @(posedge clk) begin : check_output
		tone_exp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_tones.size() == 0) begin
				$error("unexpected symbol: tdata %0h tlast %0b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = expected_tones.pop_front();
				if (m_tdata[3:0] !== want.tone) begin
					$error("tone_symbol: expected %0h, actual %0h", want.tone, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[7:4] !== 4'h0) begin
					$error("tdata padding: expected 0, actual %0h", m_tdata[7:4]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_symbol: expected %0b, actual %0b", want.last, m_tlast);
					errors++;
				end
				symbols_seen++;
			end
		end
	end

	// Output side: stall bursts whose frequency is redrawn at the start of each window.
	initial begin : drive_output_ready
		int stall_odds;
		int window_left;
		stall_odds  = 0;
		window_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (window_left == 0) begin
				stall_odds  = $urandom_range(0, 3) * 3;
				window_left = 64;
			end
			window_left--;
			if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Input side: reset, directed table, random frames, then wind down.
	initial begin : drive_input
		int i;
		int j;
		int len;
		int target;
		bit paused_mid;
		bit close_on_byte;
		stim_row_t r;
		paused_mid = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tuser  <= 1'b0;
		s_tlast  <= 1'b0;
		frame_is_open  = 1'b0;
		last_data_zero = 1'b0;

		// Empty frames, extreme bytes and the longest item are typed in.
		add_row(row(8'hA5, 1'b0, 1'b0, 1'b1, 4'd6, 36'h012012000));
		add_row(row(8'h5A, 1'b0, 1'b1, 1'b1, 4'd6, 36'h012012000));
		add_row(row(8'h00, 1'b1, 1'b1, 1'b1, 4'd8, 36'h012000120));
		add_row(row(8'hFF, 1'b1, 1'b1, 1'b1, 4'd8, 36'h012FF0120));
		add_row(row(8'h01, 1'b1, 1'b1, 1'b1, 4'd9, 36'h012013012));
		// Start flag followed by a data 1: no escape.
		add_row(row(8'h12, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		add_row(row(8'h10, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		// Escape across a byte boundary, then within bytes.
		add_row(row(8'h10, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		add_row(row(8'h01, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		add_row(row(8'h00, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		add_row(row(8'h11, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		add_row(row(8'hF0, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		// Closing item on an open frame ending in a data 0.
		add_row(row(8'hC3, 1'b0, 1'b0, 1'b0, 4'd0, 36'h0));
		add_row(row(8'h0F, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		add_row(row(8'hF0, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		// Escape right before the end flag.
		add_row(row(8'h01, 1'b1, 1'b1, 1'b0, 4'd0, 36'h0));
		add_row(row(8'h80, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		add_row(row(8'h7F, 1'b1, 1'b0, 1'b0, 4'd0, 36'h0));
		add_row(row(8'h3C, 1'b0, 1'b1, 1'b0, 4'd0, 36'h0));
		add_row(row(8'hAA, 1'b1, 1'b1, 1'b0, 4'd0, 36'h0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < directed_rows.size(); i++) begin
			r = directed_rows[i];
			send_item(r.data, r.carries, r.closes, r.typed, r.count, r.syms);
		end
		drain_outputs();

		// Random frames of 0 to 8 bytes, closed either on the last byte or by a
		// closing item, mixed with stray items of any shape.
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			calm     = (items_sent >= target - CALM_ITEMS);
			gap_odds = $urandom_range(0, 3) * 3;
			if (!paused_mid && items_sent >= target - RANDOM_ITEMS / 2) begin
				drain_outputs();
				paused_mid = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_item(8'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'b0, 4'd0, 36'h0);
			end else begin
				len = $urandom_range(0, 8);
				close_on_byte = 1'($urandom_range(0, 1));
				for (j = 0; j < len; j++)
					send_item(pick_byte(), 1'b1, close_on_byte && (j == len - 1),
						1'b0, 4'd0, 36'h0);
				if (len == 0 || !close_on_byte)
					send_item(8'($urandom), 1'b0, 1'($urandom_range(0, 1)),
						1'b0, 4'd0, 36'h0);
			end
		end

		drain_outputs();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Encoded %0d items into %0d symbols, %0d escapes and %0d closed frames.",
			items_sent, symbols_seen, escapes_made, frames_closed);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("Run timed out with %0d symbols still expected.", expected_tones.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
